// ===== src/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion block.
// Used by rmq_prep, rmq_cell and rotation_matrix_to_quaternion; no dependencies.
package rmq_pkg;

  localparam int LANES = 4;

  localparam int LANE_W = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_Z = 3;

  localparam logic [14:0] MAG_MAX = 15'h7fff;

  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } ctl_t;

endpackage

// ===== src/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion, top level: front stage, square root cell chain
// and output sign and saturation. Depends on rmq_pkg, rmq_prep and rmq_cell.
//
// A request carries the nine Q2.14 rotation elements and yields one quaternion
// (w, x, y, z): x, y and z in Q2.14 and w in unsigned Q1.14. A new request can
// be taken every cycle while the output is not stalled; the pipeline is one
// front stage plus one cell per root bit. Each cell of the chain settles one bit
// of all four roots, so the chain length sets the latency. The whole chain
// advances together, and holds only while the last cell has a result that is
// stalled at the output.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] r00,
  input  logic signed [15:0] r01,
  input  logic signed [15:0] r02,
  input  logic signed [15:0] r10,
  input  logic signed [15:0] r11,
  input  logic signed [15:0] r12,
  input  logic signed [15:0] r20,
  input  logic signed [15:0] r21,
  input  logic signed [15:0] r22,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);
  import rmq_pkg::*;

  localparam int SUM_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int VAL_W  = SUM_W - 1 + FRAC_BITS;
  localparam int ROOT_W = (VAL_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int HALF_W = (ROOT_W - 1 > 15) ? ROOT_W - 1 : 15;

  ctl_t                          ctl_s  [ROOT_W+1];
  logic [LANES-1:0][RAD_W-1:0]   rad_s  [ROOT_W+1];
  logic [LANES-1:0][REM_W-1:0]   rem_s  [ROOT_W+1];
  logic [LANES-1:0][ROOT_W-1:0]  root_s [ROOT_W+1];

  logic                          adv;
  logic [HALF_W-1:0]             half [LANES];
  logic [14:0]                   mag  [LANES];
  logic                          rem_ok;

  assign adv      = !ctl_s[ROOT_W].valid || !out_stall;
  assign in_stall = !adv;

  rmq_prep #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SUM_W),
    .ROOT_W    (ROOT_W)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .r00      (r00),
    .r01      (r01),
    .r02      (r02),
    .r10      (r10),
    .r11      (r11),
    .r12      (r12),
    .r20      (r20),
    .r21      (r21),
    .r22      (r22),
    .ctl_out  (ctl_s[0]),
    .rad_out  (rad_s[0]),
    .rem_out  (rem_s[0]),
    .root_out (root_s[0])
  );

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    rmq_cell #(
      .ROOT_W (ROOT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ctl_in   (ctl_s[i]),
      .rad_in   (rad_s[i]),
      .rem_in   (rem_s[i]),
      .root_in  (root_s[i]),
      .ctl_out  (ctl_s[i+1]),
      .rad_out  (rad_s[i+1]),
      .rem_out  (rem_s[i+1]),
      .root_out (root_s[i+1])
    );
  end

  always_comb begin
    rem_ok = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      half[l] = HALF_W'(root_s[ROOT_W][l] >> 1);
      mag[l]  = (half[l] > HALF_W'(MAG_MAX)) ? MAG_MAX : half[l][14:0];
      if (rem_s[ROOT_W][l] > REM_W'({root_s[ROOT_W][l], 1'b0})) begin
        rem_ok = 1'b0;
      end
    end
  end

  assign out_valid = ctl_s[ROOT_W].valid;
  assign quat_w    = mag[LANE_W];
  assign quat_x    = ctl_s[ROOT_W].neg_x ? -$signed({1'b0, mag[LANE_X]})
                                         : $signed({1'b0, mag[LANE_X]});
  assign quat_y    = ctl_s[ROOT_W].neg_y ? -$signed({1'b0, mag[LANE_Y]})
                                         : $signed({1'b0, mag[LANE_Y]});
  assign quat_z    = ctl_s[ROOT_W].neg_z ? -$signed({1'b0, mag[LANE_Z]})
                                         : $signed({1'b0, mag[LANE_Z]});

  // The remainder of an exact floor root never exceeds twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rem_ok)
    else $error("root remainder out of range");

  // Saturated magnitudes can never negate to the most negative code.
  a_no_min_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_x != 16'sh8000) && (quat_y != 16'sh8000)
                  && (quat_z != 16'sh8000))
    else $error("signed component reached the most negative code");

  // The chain comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  // A stalled result keeps the request path closed.
  a_hold_closes_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input open while the output is held");

endmodule

// ===== src/rmq_prep.sv =====
// Front stage: forms the four clamped diagonal combinations as root radicands
// and the three off-diagonal signs. Depends on rmq_pkg.
module rmq_prep #(
  parameter int FRAC_BITS = 14,
  parameter int SUM_W     = 19,
  parameter int ROOT_W    = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       adv,
  input  logic                                       in_valid,
  input  logic signed [15:0]                         r00,
  input  logic signed [15:0]                         r01,
  input  logic signed [15:0]                         r02,
  input  logic signed [15:0]                         r10,
  input  logic signed [15:0]                         r11,
  input  logic signed [15:0]                         r12,
  input  logic signed [15:0]                         r20,
  input  logic signed [15:0]                         r21,
  input  logic signed [15:0]                         r22,
  output rmq_pkg::ctl_t                              ctl_out,
  output logic [rmq_pkg::LANES-1:0][2*ROOT_W-1:0]    rad_out,
  output logic [rmq_pkg::LANES-1:0][ROOT_W+1:0]      rem_out,
  output logic [rmq_pkg::LANES-1:0][ROOT_W-1:0]      root_out
);
  import rmq_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;

  logic signed [SUM_W-1:0]      one;
  logic signed [SUM_W-1:0]      e00;
  logic signed [SUM_W-1:0]      e11;
  logic signed [SUM_W-1:0]      e22;
  logic signed [SUM_W-1:0]      sum [LANES];
  logic [LANES-1:0][RAD_W-1:0]  rad_next;
  logic signed [16:0]           dx;
  logic signed [16:0]           dy;
  logic signed [16:0]           dz;
  ctl_t                         ctl_next;

  always_comb begin
    one = SUM_W'(1) <<< FRAC_BITS;
    e00 = SUM_W'(r00);
    e11 = SUM_W'(r11);
    e22 = SUM_W'(r22);
    sum[LANE_W] = one + e00 + e11 + e22;
    sum[LANE_X] = one + e00 - e11 - e22;
    sum[LANE_Y] = one - e00 + e11 - e22;
    sum[LANE_Z] = one - e00 - e11 + e22;
    for (int l = 0; l < LANES; l++) begin
      if (!sum[l][SUM_W-1] && (sum[l] != '0)) begin
        rad_next[l] = RAD_W'(sum[l][SUM_W-2:0]) << FRAC_BITS;
      end else begin
        rad_next[l] = '0;
      end
    end
    dx = 17'(r21) - 17'(r12);
    dy = 17'(r02) - 17'(r20);
    dz = 17'(r10) - 17'(r01);
    ctl_next.valid = in_valid;
    ctl_next.neg_x = dx[16];
    ctl_next.neg_y = dy[16];
    ctl_next.neg_z = dz[16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_out  <= rad_next;
      rem_out  <= '0;
      root_out <= '0;
    end
  end

endmodule

// ===== src/rmq_cell.sv =====
// One cell of the square root chain: settles one root bit in each of the four
// lanes and hands the partial state to the next cell. Depends on rmq_pkg.
module rmq_cell #(
  parameter int ROOT_W = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       adv,
  input  rmq_pkg::ctl_t                              ctl_in,
  input  logic [rmq_pkg::LANES-1:0][2*ROOT_W-1:0]    rad_in,
  input  logic [rmq_pkg::LANES-1:0][ROOT_W+1:0]      rem_in,
  input  logic [rmq_pkg::LANES-1:0][ROOT_W-1:0]      root_in,
  output rmq_pkg::ctl_t                              ctl_out,
  output logic [rmq_pkg::LANES-1:0][2*ROOT_W-1:0]    rad_out,
  output logic [rmq_pkg::LANES-1:0][ROOT_W+1:0]      rem_out,
  output logic [rmq_pkg::LANES-1:0][ROOT_W-1:0]      root_out
);
  import rmq_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [LANES-1:0][REM_W-1:0]  cur;
  logic [LANES-1:0][REM_W-1:0]  trial;
  logic [LANES-1:0]             ge;
  logic [LANES-1:0][RAD_W-1:0]  rad_next;
  logic [LANES-1:0][REM_W-1:0]  rem_next;
  logic [LANES-1:0][ROOT_W-1:0] root_next;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cur[l]       = {rem_in[l][REM_W-3:0], rad_in[l][RAD_W-1 -: 2]};
      trial[l]     = {root_in[l], 2'b01};
      ge[l]        = cur[l] >= trial[l];
      rem_next[l]  = ge[l] ? (cur[l] - trial[l]) : cur[l];
      root_next[l] = {root_in[l][ROOT_W-2:0], ge[l]};
      rad_next[l]  = rad_in[l] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_out  <= rad_next;
      rem_out  <= rem_next;
      root_out <= root_next;
    end
  end

endmodule

// ===== tb/rotation_matrix_to_quaternion_tb.sv =====
// Self-checking testbench for rotation_matrix_to_quaternion: directed and random
// matrices, random idling on both channels, and a scoreboard of predicted quaternions.
// Depends on the RTL top level rotation_matrix_to_quaternion and on rmq_pkg.
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int FRAC_BITS    = 14;
  localparam int IDLE_PCT     = 22;
  localparam int DRAIN_CYCLES = 40;
  localparam int STUCK_LIMIT  = 2000;
  localparam int SHOW_LIMIT   = 10;

  typedef struct {
    logic signed [15:0] r00, r01, r02;
    logic signed [15:0] r10, r11, r12;
    logic signed [15:0] r20, r21, r22;
  } rot_mat_t;

  typedef struct {
    logic [14:0]        w;
    logic signed [15:0] x, y, z;
  } quat_t;

  class quat_scoreboard;
    quat_t expected_q[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root, bitv, rem;
      root = 0;
      rem  = v;
      bitv = 64'h1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem  = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function logic [14:0] half_root(longint s);
      longint unsigned r;
      if (s <= 0) return '0;
      r = floor_sqrt(longint'(s) << FRAC_BITS) >> 1;
      if (r > longint'(MAG_MAX)) r = longint'(MAG_MAX);
      return r[14:0];
    endfunction

    function logic signed [15:0] signed_part(logic [14:0] mag, longint d);
      logic [15:0] m16;
      m16 = {1'b0, mag};
      if (d < 0) return 16'h0000 - m16;
      return m16;
    endfunction

    function quat_t predict_quat(rot_mat_t m);
      longint one, a00, a01, a02, a10, a11, a12, a20, a21, a22;
      quat_t q;
      one = longint'(1) << FRAC_BITS;
      a00 = m.r00; a01 = m.r01; a02 = m.r02;
      a10 = m.r10; a11 = m.r11; a12 = m.r12;
      a20 = m.r20; a21 = m.r21; a22 = m.r22;
      q.w = half_root(one + a00 + a11 + a22);
      q.x = signed_part(half_root(one + a00 - a11 - a22), a21 - a12);
      q.y = signed_part(half_root(one - a00 + a11 - a22), a02 - a20);
      q.z = signed_part(half_root(one - a00 - a11 + a22), a10 - a01);
      return q;
    endfunction

    function void note_matrix(rot_mat_t m);
      expected_q.push_back(predict_quat(m));
    endfunction

    function void check_quat(quat_t got);
      quat_t exp_q;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("unexpected quaternion w=%0d x=%0d y=%0d z=%0d",
                   got.w, got.x, got.y, got.z);
        return;
      end
      exp_q = expected_q.pop_front();
      if (got.w !== exp_q.w || got.x !== exp_q.x || got.y !== exp_q.y ||
          got.z !== exp_q.z) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                   exp_q.w, exp_q.x, exp_q.y, exp_q.z, got.w, got.x, got.y, got.z);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flush_leftovers();
      if (expected_q.size() != 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0d quaternions never arrived", expected_q.size());
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] r00 = '0, r01 = '0, r02 = '0;
  logic signed [15:0] r10 = '0, r11 = '0, r12 = '0;
  logic signed [15:0] r20 = '0, r21 = '0, r22 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [14:0]        quat_w;
  logic signed [15:0] quat_x, quat_y, quat_z;

  quat_scoreboard quat_sb = new();
  bit             idle_on = 1'b1;
  int             stuck_cycles = 0;
  rot_mat_t       seen_mat;
  quat_t          seen_quat;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .r00(r00), .r01(r01), .r02(r02),
    .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22),
    .out_valid(out_valid), .out_stall(out_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall = idle_on && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Accepted requests feed the scoreboard before the output side is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen_mat = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
        quat_sb.note_matrix(seen_mat);
      end
      if (out_valid && !out_stall) begin
        seen_quat = '{quat_w, quat_x, quat_y, quat_z};
        quat_sb.check_quat(seen_quat);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  function automatic rot_mat_t mk(int a, int b, int c, int d, int e, int f,
                                  int g, int h, int i);
    rot_mat_t m;
    m.r00 = a[15:0]; m.r01 = b[15:0]; m.r02 = c[15:0];
    m.r10 = d[15:0]; m.r11 = e[15:0]; m.r12 = f[15:0];
    m.r20 = g[15:0]; m.r21 = h[15:0]; m.r22 = i[15:0];
    return m;
  endfunction

  function automatic real rand_unit();
    return real'($urandom_range(0, 65535)) / 32767.5 - 1.0;
  endfunction

  function automatic logic signed [15:0] to_q14(real v);
    int t;
    t = $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5)) + $urandom_range(0, 6) - 3;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  function automatic rot_mat_t random_rotation();
    real qw, qx, qy, qz, n;
    rot_mat_t m;
    qw = rand_unit(); qx = rand_unit(); qy = rand_unit(); qz = rand_unit();
    n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    if (n < 0.001) begin
      qw = 1.0; n = 1.0;
    end
    qw = qw / n; qx = qx / n; qy = qy / n; qz = qz / n;
    m.r00 = to_q14(1.0 - 2.0 * (qy * qy + qz * qz));
    m.r01 = to_q14(2.0 * (qx * qy - qz * qw));
    m.r02 = to_q14(2.0 * (qx * qz + qy * qw));
    m.r10 = to_q14(2.0 * (qx * qy + qz * qw));
    m.r11 = to_q14(1.0 - 2.0 * (qx * qx + qz * qz));
    m.r12 = to_q14(2.0 * (qy * qz - qx * qw));
    m.r20 = to_q14(2.0 * (qx * qz - qy * qw));
    m.r21 = to_q14(2.0 * (qy * qz + qx * qw));
    m.r22 = to_q14(1.0 - 2.0 * (qx * qx + qy * qy));
    return m;
  endfunction

  function automatic rot_mat_t random_matrix();
    rot_mat_t m;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      m = random_rotation();
    end else if (pick < 80) begin
      m = mk($urandom_range(0, 32768) - 16384, $urandom, $urandom,
             $urandom, $urandom_range(0, 32768) - 16384, $urandom,
             $urandom, $urandom, $urandom_range(0, 32768) - 16384);
    end else begin
      m = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
    end
    // Equal off-diagonal pairs give a zero sign difference.
    if ($urandom_range(0, 99) < 15) m.r21 = m.r12;
    if ($urandom_range(0, 99) < 15) m.r02 = m.r20;
    if ($urandom_range(0, 99) < 15) m.r10 = m.r01;
    return m;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_matrix(rot_mat_t m);
    while (idle_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    r00 = m.r00; r01 = m.r01; r02 = m.r02;
    r10 = m.r10; r11 = m.r11; r12 = m.r12;
    r20 = m.r20; r21 = m.r21; r22 = m.r22;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(int count, bit with_idle);
    idle_on = with_idle;
    repeat (count) send_matrix(random_matrix());
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (quat_sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;

    send_matrix(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_matrix(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_matrix(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                   -32768));
    send_matrix(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    send_matrix(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    send_matrix(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    send_matrix(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    // Zero magnitude paired with a negative difference on every axis.
    send_matrix(mk(16384, 100, 0, 0, 16384, 100, 100, 0, 16384));
    send_matrix(mk(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
    send_matrix(mk(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
    send_matrix(mk(0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
    send_matrix(mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767));
    send_matrix(mk(32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767));
    send_matrix(mk(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                   16'h5555, 16'haaaa, 16'h5555));
    send_matrix(mk(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                   16'haaaa, 16'h5555, 16'haaaa));
    send_matrix(mk(-32768, 5, 7, 5, -32768, 7, 7, 7, -32768));
    send_matrix(mk(32767, 1, -1, -1, -32768, 1, 1, -1, -32768));
    send_matrix(mk(1, 0, 0, 0, 1, 0, 0, 0, -16387));
    send_matrix(mk(8192, -9000, 9000, 9000, 8192, -9000, -9000, 9000, 8192));

    run_random(700, 1'b1);
    wait_drained();
    run_random(350, 1'b0);
    run_random(600, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    quat_sb.flush_leftovers();
    if (quat_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
